/* rtl/assert_macros.svh */
// Assertion macros for the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/blt_pkg.sv */
// Types, constants and the sine ROM builder for the brake light detector.
`timescale 1ns / 1ps

package blt_pkg;

    // Field and state widths
    localparam int ACCEL_WIDTH  = 16;
    localparam int AVG_W        = ACCEL_WIDTH + 5;
    localparam int SINE_ENTRIES = 256;
    localparam int SINE_AW      = $clog2(SINE_ENTRIES);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    // Polynomial coefficients in Q2.30
    localparam longint Q30 = 64'sd1073741824;
    localparam longint C1  = 64'sd1686629713;
    localparam longint C3  = 64'sd693598667;
    localparam longint C5  = 64'sd85569306;
    localparam longint C7  = 64'sd5026996;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE,
        REG_TRIP_LEVEL,
        REG_HOLD_MS,
        REG_GLOW_FLOOR,
        REG_GLOW_PEAK,
        REG_BREATH_STEP,
        REG_FADE_IN_RATE,
        REG_FADE_OUT_RATE
    } blt_reg_t;

    // Datapath operations issued by the sequencer
    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_BRAKE,
        OP_MULB,
        OP_TGT,
        OP_MULF,
        OP_FIN
    } blt_op_t;

    typedef struct packed {
        blt_op_t op;
        logic    fire;
    } blt_ctl_t;

    typedef struct packed {
        logic out_busy;
        logic breath;
    } blt_dp_stat_t;

    typedef struct packed {
        logic        mode;
        logic [14:0] trip_level;
        logic [31:0] hold_ms;
        logic [15:0] glow_floor;
        logic [15:0] glow_peak;
        logic [15:0] breath_step;
        logic [15:0] fade_in_rate;
        logic [14:0] fade_out_rate;
    } blt_cfg_t;

    typedef struct packed {
        logic signed [ACCEL_WIDTH-1:0] accel_z;
        logic        [31:0]            time_ms;
    } blt_in_t;

    typedef struct packed {
        logic [15:0] level;
        logic [7:0]  red_level;
        logic        is_braking;
    } blt_out_t;

    typedef logic [15:0] sine_rom_t [SINE_ENTRIES];

    // Evaluate (sin+1)/2 in Q0.16 for a 16-bit turn fraction
    function automatic logic [15:0] sine_value(input logic [15:0] turn);
        logic [1:0] quad;
        longint     r;
        longint     u;
        longint     u2;
        longint     p;
        longint     s;
        quad = turn[15:14];
        r    = longint'(turn[13:0]);
        if (quad == 2'd1 || quad == 2'd3)
        begin
            r = 64'sd16384 - r;
        end
        u  = r <<< 16;
        u2 = (u * u) / Q30;
        p  = -C7;
        p  = C5 + (p * u2) / Q30;
        p  = -C3 + (p * u2) / Q30;
        p  = C1 + (p * u2) / Q30;
        s  = (p * u) / Q30;
        if (quad[1])
        begin
            s = -s;
        end
        s = (s + Q30) / 64'sd32768;
        if (s < 0)
        begin
            s = 0;
        end
        if (s > 64'sd65535)
        begin
            s = 64'sd65535;
        end
        return s[15:0];
    endfunction

    // Build the breathing ROM, one entry per address step of the phase
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        logic [15:0] turn;
        for (int i = 0; i < SINE_ENTRIES; i++)
        begin
            turn   = 16'(i << (16 - SINE_AW));
            rom[i] = sine_value(turn);
        end
        return rom;
    endfunction

endpackage

/* rtl/blt_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps

module blt_seq
    import blt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  blt_dp_stat_t stat,
    output blt_ctl_t     ctl
);

    localparam int STEP_W = 3;

    localparam logic [STEP_W-1:0] STEP_ACCEPT = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FADE   = 3'd4;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_SKIP_BREATH,
        COND_WAIT_OUT
    } cond_t;

    typedef struct packed {
        blt_op_t           op;
        cond_t             cond;
        logic [STEP_W-1:0] jump;
    } uword_t;

    // Control program, one word per step
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            3'd0:    w = '{op: OP_ACCEPT, cond: COND_WAIT_IN,     jump: STEP_ACCEPT};
            3'd1:    w = '{op: OP_BRAKE,  cond: COND_SKIP_BREATH, jump: STEP_FADE};
            3'd2:    w = '{op: OP_MULB,   cond: COND_NEXT,        jump: STEP_ACCEPT};
            3'd3:    w = '{op: OP_TGT,    cond: COND_NEXT,        jump: STEP_ACCEPT};
            3'd4:    w = '{op: OP_MULF,   cond: COND_NEXT,        jump: STEP_ACCEPT};
            3'd5:    w = '{op: OP_FIN,    cond: COND_WAIT_OUT,    jump: STEP_ACCEPT};
            default: w = '{op: OP_ACCEPT, cond: COND_WAIT_IN,     jump: STEP_ACCEPT};
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    uword_t            word;
    logic              fire;

    // Decode the current word and pick the next step
    always_comb
    begin
        word      = ucode(step_reg);
        fire      = 1'b1;
        step_next = step_reg + 3'd1;
        case (word.cond)
            COND_WAIT_IN:
            begin
                fire      = in_valid;
                step_next = in_valid ? step_reg + 3'd1 : step_reg;
            end
            COND_SKIP_BREATH:
            begin
                step_next = stat.breath ? step_reg + 3'd1 : word.jump;
            end
            COND_WAIT_OUT:
            begin
                fire      = !stat.out_busy;
                step_next = stat.out_busy ? step_reg : word.jump;
            end
            default:
            begin
                step_next = step_reg + 3'd1;
            end
        endcase
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_ACCEPT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctl.op   = word.op;
    assign ctl.fire = fire;

endmodule

/* rtl/blt_datapath.sv */
// Datapath: brake state, average, phase, shared multiplier and result register.
`timescale 1ns / 1ps

module blt_datapath
    import blt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  blt_ctl_t     ctl,
    input  blt_cfg_t     cfg,
    input  blt_in_t      sample,
    input  logic         result_stall,
    output blt_dp_stat_t stat,
    output logic         result_valid,
    output blt_out_t     result
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Truncate a Q16 product toward zero
    function automatic logic signed [17:0] q16_trunc(input logic signed [33:0] p);
        logic signed [17:0] hi;
        hi = p[33:16];
        if (p[33] && (p[15:0] != 16'd0))
        begin
            hi = hi + 18'sd1;
        end
        return hi;
    endfunction

    // State
    logic signed [AVG_W-1:0] avg_reg;
    logic                    brake_reg;
    logic [31:0]             last_reg;
    logic [15:0]             phase_reg;
    logic [15:0]             glow_reg;
    logic                    result_valid_reg;

    // Working registers
    logic signed [ACCEL_WIDTH-1:0] accel_reg;
    logic [31:0]                   time_reg;
    logic [15:0]                   sine_reg;
    logic [15:0]                   target_reg;
    logic [15:0]                   rate_reg;
    logic signed [33:0]            prod_reg;
    blt_out_t                      result_reg;

    logic signed [AVG_W:0]   avg_sum;
    logic signed [AVG_W-1:0] avg_next;
    logic signed [AVG_W+1:0] dev;
    logic signed [AVG_W+1:0] dev_neg;
    logic [AVG_W:0]          dev_mag;
    logic [AVG_W:0]          thr_scaled;
    logic                    trig;
    logic [31:0]             elapsed;
    logic                    brake_next;
    logic [15:0]             phase_next;
    logic [16:0]             rate3;
    logic [15:0]             rate_breath;
    logic signed [16:0]      mul_a;
    logic signed [16:0]      mul_b;
    logic signed [33:0]      mul_p;
    logic signed [17:0]      q;
    logic signed [17:0]      tgt_sum;
    logic signed [17:0]      glow_sum;
    logic [15:0]             glow_clamp;
    logic [24:0]             red_sum;

    // Average update from the incoming sample: avg - floor(avg/32) + accel
    always_comb
    begin
        avg_sum  = (AVG_W+1)'(avg_reg) - (AVG_W+1)'(avg_reg >>> 5)
                 + (AVG_W+1)'(sample.accel_z);
        avg_next = avg_sum[AVG_W-1:0];
    end

    // Deviation test, hold timer and phase advance
    always_comb
    begin
        dev        = ((AVG_W+2)'(accel_reg) <<< 5) - (AVG_W+2)'(avg_reg);
        dev_neg    = -dev;
        dev_mag    = dev[AVG_W+1] ? dev_neg[AVG_W:0] : dev[AVG_W:0];
        thr_scaled = (AVG_W+1)'({cfg.trip_level, 5'b0});
        trig       = dev_mag > thr_scaled;
        elapsed    = time_reg - last_reg;
        brake_next = trig || (brake_reg && !(elapsed > cfg.hold_ms));
        phase_next = phase_reg + cfg.breath_step;
        rate3      = {1'b0, cfg.fade_out_rate, 1'b0} + 17'(cfg.fade_out_rate);
        rate_breath = rate3[16] ? 16'hFFFF : rate3[15:0];
    end

    // Shared multiplier operands
    always_comb
    begin
        if (ctl.op == OP_MULB)
        begin
            mul_a = $signed({1'b0, cfg.glow_peak}) - $signed({1'b0, cfg.glow_floor});
            mul_b = $signed({1'b0, sine_reg});
        end
        else
        begin
            mul_a = $signed({1'b0, target_reg}) - $signed({1'b0, glow_reg});
            mul_b = $signed({1'b0, rate_reg});
        end
        mul_p = mul_a * mul_b;
    end

    // Target from the breathing product, fade step, clamp and LED scale
    always_comb
    begin
        q        = q16_trunc(prod_reg);
        tgt_sum  = $signed({2'b0, cfg.glow_floor}) + q;
        glow_sum = $signed({2'b0, glow_reg}) + q;
        if (glow_sum[17])
        begin
            glow_clamp = 16'h0000;
        end
        else if (glow_sum[16])
        begin
            glow_clamp = 16'hFFFF;
        end
        else
        begin
            glow_clamp = glow_sum[15:0];
        end
        red_sum = {1'b0, glow_clamp, 8'b0} - 25'(glow_clamp) + 25'd255;
    end

    // Hold persistent state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg          <= '0;
            brake_reg        <= 1'b0;
            last_reg         <= '0;
            phase_reg        <= '0;
            glow_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.fire && ctl.op == OP_ACCEPT && !brake_reg)
            begin
                avg_reg <= avg_next;
            end
            if (ctl.fire && ctl.op == OP_BRAKE)
            begin
                brake_reg <= brake_next;
                phase_reg <= phase_next;
                if (trig)
                begin
                    last_reg <= time_reg;
                end
            end
            if (ctl.fire && ctl.op == OP_FIN)
            begin
                glow_reg         <= glow_clamp;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Load working registers for each step
    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            case (ctl.op)
                OP_ACCEPT:
                begin
                    accel_reg <= sample.accel_z;
                    time_reg  <= sample.time_ms;
                end
                OP_BRAKE:
                begin
                    sine_reg <= SINE_ROM[phase_next[15 -: SINE_AW]];
                    if (brake_next)
                    begin
                        target_reg <= 16'hFFFF;
                        rate_reg   <= cfg.fade_in_rate;
                    end
                    else if (!cfg.mode)
                    begin
                        target_reg <= 16'h0000;
                        rate_reg   <= {1'b0, cfg.fade_out_rate};
                    end
                    else
                    begin
                        rate_reg <= rate_breath;
                    end
                end
                OP_MULB, OP_MULF:
                begin
                    prod_reg <= mul_p;
                end
                OP_TGT:
                begin
                    target_reg <= tgt_sum[15:0];
                end
                OP_FIN:
                begin
                    result_reg.level      <= glow_clamp;
                    result_reg.red_level  <= red_sum[23:16];
                    result_reg.is_braking <= brake_reg;
                end
                default:
                begin
                    prod_reg <= prod_reg;
                end
            endcase
        end
    end

    assign stat.out_busy = result_valid_reg && result_stall;
    assign stat.breath   = cfg.mode && !brake_next;
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

endmodule

/* rtl/brake_light_detector.sv */
// Top level: configuration registers, sequencer and datapath of the brake light detector.
//
//  channel  | direction | handshake           | contents
//  ---------+-----------+---------------------+-------------------------------------
//  sample   | in        | sample_valid/stall  | accel_z (Q5.10 signed), time_ms
//  result   | out       | result_valid/stall  | level (Q0.16), red_level, is_braking
//  cfg      | in        | cfg_valid/ready     | cfg_index, cfg_data (32 bits)
//
// A request runs the accept, brake, fade multiply and final steps, and in breathing mode
// also the breathing multiply and target steps, around the one shared 17x17 multiplier.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only the final step waits while that register is still held.
// Reset is asynchronous, active low, loads register defaults and clears persistent state.
`timescale 1ns / 1ps

module brake_light_detector
    import blt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  blt_in_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output blt_out_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    blt_cfg_t     cfg_reg;
    blt_ctl_t     ctl;
    blt_dp_stat_t stat;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= 1'b0;
            cfg_reg.trip_level    <= 15'd512;
            cfg_reg.hold_ms       <= 32'd5000;
            cfg_reg.glow_floor    <= 16'd5140;
            cfg_reg.glow_peak     <= 16'd15420;
            cfg_reg.breath_step   <= 16'd219;
            cfg_reg.fade_in_rate  <= 16'd16384;
            cfg_reg.fade_out_rate <= 15'd983;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (blt_reg_t'(cfg_index))
                REG_MODE:          cfg_reg.mode          <= cfg_data[0];
                REG_TRIP_LEVEL:    cfg_reg.trip_level    <= cfg_data[14:0];
                REG_HOLD_MS:       cfg_reg.hold_ms       <= cfg_data[31:0];
                REG_GLOW_FLOOR:    cfg_reg.glow_floor    <= cfg_data[15:0];
                REG_GLOW_PEAK:     cfg_reg.glow_peak     <= cfg_data[15:0];
                REG_BREATH_STEP:   cfg_reg.breath_step   <= cfg_data[15:0];
                REG_FADE_IN_RATE:  cfg_reg.fade_in_rate  <= cfg_data[15:0];
                REG_FADE_OUT_RATE: cfg_reg.fade_out_rate <= cfg_data[14:0];
                default:           cfg_reg.mode          <= cfg_reg.mode;
            endcase
        end
    end

    assign cfg_ready    = 1'b1;
    assign sample_stall = (ctl.op != OP_ACCEPT);

    blt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_valid),
        .stat     (stat),
        .ctl      (ctl)
    );

    blt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cfg          (cfg_reg),
        .sample       (sample),
        .result_stall (result_stall),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

`include "assert_macros.svh"

    // An accepted request moves the program to the brake step
    `ASSERT_NEXT(a_accept_to_brake, sample_valid && !sample_stall, ctl.op == OP_BRAKE, "accept did not advance to brake step")
    // The final step loads the result and returns to accept
    `ASSERT_NEXT(a_finish_loads_result, ctl.op == OP_FIN && ctl.fire, result_valid && ctl.op == OP_ACCEPT, "final step did not load result")
    // A result appears only after the final step fired
    `ASSERT_IMPLIES(a_result_from_finish, $rose(result_valid), $past(ctl.op == OP_FIN && ctl.fire), "result valid without final step")

endmodule
